// File: hw/rtl/mbrtu_pkg.sv
// Shared types, codes and the CRC-16 step of the Modbus RTU response receiver.
// Depends on nothing; used by modbus_rtu_response_receiver.
`default_nettype none

package mbrtu_pkg;

   // Largest response frame the receiver will accept, in bytes.
   localparam int unsigned MAX_FRAME = 256;

   localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
   localparam logic [7:0]  FUNC_WRITE_SINGLE = 8'h06;
   localparam logic [15:0] CRC_INIT          = 16'hFFFF;
   localparam logic [15:0] CRC_POLY          = 16'hA001;
   localparam logic [8:0]  MIN_FRAME         = 9'd5;

   typedef enum logic [1:0] {
      REQ_START = 2'd0,
      REQ_RETRY = 2'd1,
      REQ_BYTE  = 2'd2,
      REQ_TICK  = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      CSR_BUFFER_CAPACITY = 2'd0,
      CSR_REQUEST_LENGTH  = 2'd1,
      CSR_TIMEOUT_LIMIT   = 2'd2,
      CSR_ATTEMPT_LIMIT   = 2'd3
   } csr_reg_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_TIMEOUT    = 3'd1,
      ST_UNKNOWN_FN = 3'd2,
      ST_BUF_SMALL  = 3'd3,
      ST_INCOMPLETE = 3'd4,
      ST_CRC_ERROR  = 3'd5
   } status_type;

   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
      logic [7:0] byte_index;
      status_type status;
      logic       retry_allowed;
      logic       last;
   } result_type;

   // One byte of the reflected CRC-16 used by Modbus RTU.
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/modbus_rtu_response_receiver.sv
// Top level of the Modbus RTU response receiver: frame tracking, CRC check and result queue.
// Depends on mbrtu_pkg.
//
// After a start or retry command the block follows the slave's response one byte at a
// time, echoing every byte with its index, and closes each frame with a single status
// transfer (ok, timeout, unknown function, buffer too small, incomplete or CRC mismatch)
// that also says whether another attempt is allowed. Every input transfer is handled in
// the cycle it is taken: the frame state and the CRC-16 update in one step, and its one
// or two results are written into a four-entry result queue. The input side takes a
// transfer in any cycle in which the queue has room for two results, so it sustains one
// item per clock; the result side delivers one result per clock while rsp_tready is high,
// which limits a stream of items that each produce two results. Results are registered
// in the queue before they appear on the output.
`default_nettype none

module modbus_rtu_response_receiver (
   input  wire logic        clock,
   input  wire logic        reset,
   // Input channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  wire logic [1:0]  req_tuser,   // [1:0] req_type
   // Result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [7:0] data_byte, [15:8] byte_index,
                                         // [18:16] status, [19] retry_allowed, [23:20] zero
   output logic             rsp_tuser,   // [0] kind
   output logic             rsp_tlast,
   // Configuration
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   // Configuration registers
   logic [8:0]  cap_ff;
   logic [8:0]  reqlen_ff;
   logic [15:0] tlim_ff;
   logic [3:0]  alim_ff;

   // Frame state
   logic        receiving_ff, receiving_in;
   logic [8:0]  byte_count_ff, byte_count_in;
   logic [8:0]  expected_ff, expected_in;
   logic [7:0]  func_ff, func_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] trail_ff, trail_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic [3:0]  attempt_ff, attempt_in;

   // Result queue
   mbrtu_pkg::result_type q_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;

   logic                  accept;
   logic                  pop;
   mbrtu_pkg::req_kind_type req_kind;
   logic [7:0]            rx_byte;
   logic [8:0]            eff_cap;
   logic [16:0]           tick_next;
   logic [8:0]            bc_next;
   logic [15:0]           crc_next;
   logic [15:0]           trail_next;
   logic [8:0]            exp_next;
   logic [8:0]            len_read;
   logic [15:0]           rx_crc;
   logic                  has_data;
   logic                  fin;
   mbrtu_pkg::status_type fin_status;
   mbrtu_pkg::result_type data_res, stat_res, e0, e1;
   logic [1:0]            push_cnt;
   mbrtu_pkg::result_type head;

   assign accept   = req_tvalid & req_tready;
   assign pop      = rsp_tvalid & rsp_tready;
   assign req_kind = mbrtu_pkg::req_kind_type'(req_tuser);
   assign rx_byte  = req_tdata;

   // Room for two results is required so any item can be taken without a stall.
   assign req_tready = (count_ff <= 3'd2);

   always_comb begin
      if (cap_ff == 9'd0) begin
         eff_cap = 9'd1;
      end else if (cap_ff > 9'(mbrtu_pkg::MAX_FRAME)) begin
         eff_cap = 9'(mbrtu_pkg::MAX_FRAME);
      end else begin
         eff_cap = cap_ff;
      end
   end

   // Per-byte datapath, evaluated for every item and used on byte and tick transfers.
   always_comb begin
      tick_next  = {1'b0, elapsed_ff} + 17'd1;
      bc_next    = byte_count_ff + 9'd1;
      crc_next   = (byte_count_ff >= 9'd2) ? mbrtu_pkg::crc16_byte(crc_ff, trail_ff[15:8])
                                           : crc_ff;
      trail_next = {trail_ff[7:0], rx_byte};
      len_read   = mbrtu_pkg::MIN_FRAME + {1'b0, rx_byte};
      // The CRC arrives low byte first.
      rx_crc     = {trail_next[7:0], trail_next[15:8]};
   end

   always_comb begin
      receiving_in  = receiving_ff;
      byte_count_in = byte_count_ff;
      expected_in   = expected_ff;
      func_in       = func_ff;
      crc_in        = crc_ff;
      trail_in      = trail_ff;
      elapsed_in    = elapsed_ff;
      attempt_in    = attempt_ff;
      exp_next      = expected_ff;
      has_data      = 1'b0;
      fin           = 1'b0;
      fin_status    = mbrtu_pkg::ST_OK;

      if (accept) begin
         case (req_kind)
            mbrtu_pkg::REQ_START, mbrtu_pkg::REQ_RETRY: begin
               if (req_kind == mbrtu_pkg::REQ_START) begin
                  attempt_in = 4'd1;
               end else if (attempt_ff != 4'hF) begin
                  attempt_in = attempt_ff + 4'd1;
               end
               receiving_in  = 1'b1;
               byte_count_in = 9'd0;
               expected_in   = eff_cap;
               func_in       = 8'h00;
               crc_in        = mbrtu_pkg::CRC_INIT;
               trail_in      = 16'h0000;
               elapsed_in    = 16'h0000;
            end
            mbrtu_pkg::REQ_TICK: begin
               if (receiving_ff) begin
                  if (tick_next > {1'b0, tlim_ff}) begin
                     fin        = 1'b1;
                     fin_status = mbrtu_pkg::ST_TIMEOUT;
                  end else begin
                     elapsed_in = tick_next[15:0];
                  end
               end
            end
            mbrtu_pkg::REQ_BYTE: begin
               if (receiving_ff) begin
                  if (byte_count_ff >= eff_cap) begin
                     // Capacity was lowered under a running frame.
                     fin        = 1'b1;
                     fin_status = mbrtu_pkg::ST_BUF_SMALL;
                  end else begin
                     has_data      = 1'b1;
                     crc_in        = crc_next;
                     trail_in      = trail_next;
                     byte_count_in = bc_next;
                     if (byte_count_ff == 9'd1) begin
                        func_in = rx_byte;
                     end
                     if (bc_next == 9'd3) begin
                        if (func_ff == mbrtu_pkg::FUNC_READ_HOLDING) begin
                           exp_next = len_read;
                           if (len_read > eff_cap) begin
                              fin        = 1'b1;
                              fin_status = mbrtu_pkg::ST_BUF_SMALL;
                           end
                        end else if (func_ff == mbrtu_pkg::FUNC_WRITE_SINGLE) begin
                           exp_next = (reqlen_ff < eff_cap) ? reqlen_ff : eff_cap;
                        end else if (func_ff[7]) begin
                           exp_next = (mbrtu_pkg::MIN_FRAME < eff_cap) ? mbrtu_pkg::MIN_FRAME
                                                                       : eff_cap;
                        end else begin
                           fin        = 1'b1;
                           fin_status = mbrtu_pkg::ST_UNKNOWN_FN;
                        end
                     end
                     expected_in = exp_next;
                     if (!fin && bc_next >= exp_next) begin
                        fin = 1'b1;
                        if (bc_next < mbrtu_pkg::MIN_FRAME) begin
                           fin_status = mbrtu_pkg::ST_INCOMPLETE;
                        end else if (rx_crc == crc_next) begin
                           fin_status = mbrtu_pkg::ST_OK;
                        end else begin
                           fin_status = mbrtu_pkg::ST_CRC_ERROR;
                        end
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end

      if (fin) begin
         receiving_in = 1'b0;
      end
   end

   // Assemble the one or two results of this transfer.
   always_comb begin
      data_res               = '0;
      data_res.kind          = mbrtu_pkg::KIND_DATA;
      data_res.data_byte     = rx_byte;
      data_res.byte_index    = byte_count_ff[7:0];
      data_res.status        = mbrtu_pkg::ST_OK;

      stat_res               = '0;
      stat_res.kind          = mbrtu_pkg::KIND_STATUS;
      stat_res.status        = fin_status;
      stat_res.retry_allowed = (fin_status != mbrtu_pkg::ST_OK) && (attempt_ff < alim_ff);
      stat_res.last          = 1'b1;

      e0       = data_res;
      e1       = stat_res;
      push_cnt = 2'd0;
      if (has_data && fin) begin
         push_cnt = 2'd2;
      end else if (has_data) begin
         e0.last  = 1'b1;
         push_cnt = 2'd1;
      end else if (fin) begin
         e0       = stat_res;
         push_cnt = 2'd1;
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff + push_cnt;
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff + {1'b0, push_cnt} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff        <= 9'd256;
         reqlen_ff     <= 9'd8;
         tlim_ff       <= 16'd1000;
         alim_ff       <= 4'd3;
         receiving_ff  <= 1'b0;
         byte_count_ff <= 9'd0;
         expected_ff   <= 9'd0;
         func_ff       <= 8'h00;
         crc_ff        <= mbrtu_pkg::CRC_INIT;
         trail_ff      <= 16'h0000;
         elapsed_ff    <= 16'h0000;
         attempt_ff    <= 4'd0;
         wr_ptr_ff     <= 2'd0;
         rd_ptr_ff     <= 2'd0;
         count_ff      <= 3'd0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               mbrtu_pkg::CSR_BUFFER_CAPACITY: cap_ff    <= csr_data[8:0];
               mbrtu_pkg::CSR_REQUEST_LENGTH:  reqlen_ff <= csr_data[8:0];
               mbrtu_pkg::CSR_TIMEOUT_LIMIT:   tlim_ff   <= csr_data;
               mbrtu_pkg::CSR_ATTEMPT_LIMIT:   alim_ff   <= csr_data[3:0];
               default: begin
               end
            endcase
         end
         receiving_ff  <= receiving_in;
         byte_count_ff <= byte_count_in;
         expected_ff   <= expected_in;
         func_ff       <= func_in;
         crc_ff        <= crc_in;
         trail_ff      <= trail_in;
         elapsed_ff    <= elapsed_in;
         attempt_ff    <= attempt_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         q_ff[wr_ptr_ff] <= e0;
      end
      if (push_cnt == 2'd2) begin
         q_ff[wr_ptr_ff + 2'd1] <= e1;
      end
   end

   assign head       = q_ff[rd_ptr_ff];
   assign rsp_tvalid = (count_ff != 3'd0);
   assign rsp_tdata  = {4'b0000, head.retry_allowed, head.status, head.byte_index,
                        head.data_byte};
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.last;

`ifndef NO_ASSERTIONS
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'd4)
      else $error("result queue holds more than four entries");

   a_status_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == mbrtu_pkg::KIND_STATUS) |-> rsp_tlast)
      else $error("status transfer not marked last");

   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      accept && !receiving_ff &&
      (req_kind == mbrtu_pkg::REQ_BYTE || req_kind == mbrtu_pkg::REQ_TICK)
      |=> count_ff <= $past(count_ff))
      else $error("idle receiver produced a result");

   a_start_receives: assert property (@(posedge clock) disable iff (reset)
      accept && (req_kind == mbrtu_pkg::REQ_START || req_kind == mbrtu_pkg::REQ_RETRY)
      |=> receiving_ff && (byte_count_ff == 9'd0))
      else $error("start did not open a frame");
`endif

endmodule

`default_nettype wire
